[rtl/core/kmdr_pkg.sv]
// Shared types and constants for the key matrix debounce and repeat block.
package kmdr_pkg;

  localparam int unsigned KEY_MATRIX_W = 64;
  localparam int unsigned TICK_W       = 16;
  localparam int unsigned KEY_ID_W     = 6;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_REPEAT_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TICKS         = 2'd2;

  localparam logic [TICK_W-1:0] DEBOUNCE_TICKS_RST       = 16'd20;
  localparam logic [TICK_W-1:0] INITIAL_REPEAT_TICKS_RST = 16'd500;
  localparam logic [TICK_W-1:0] REPEAT_TICKS_RST         = 16'd100;

  localparam logic EVENT_BREAK = 1'b0;
  localparam logic EVENT_MAKE  = 1'b1;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_DEB,
    SEQ_SCAN,
    SEQ_REP,
    SEQ_FLUSH
  } seq_e;

  typedef enum logic [1:0] {
    DEB_WAIT   = 2'd0,
    DEB_IDLE   = 2'd1,
    DEB_SETTLE = 2'd2
  } deb_phase_e;

  typedef enum logic [1:0] {
    REP_IDLE    = 2'd0,
    REP_MAKE    = 2'd1,
    REP_INITIAL = 2'd2,
    REP_REPEAT  = 2'd3
  } rep_phase_e;

endpackage

[rtl/core/kmdr_if.sv]
// Handshake channels: key snapshot input and key event output.
interface kmdr_in_if;
  logic                                valid;
  logic                                ready;
  logic [kmdr_pkg::KEY_MATRIX_W-1:0]   key_matrix;
  logic [kmdr_pkg::TICK_W-1:0]         now_ticks;

  modport source (output valid, output key_matrix, output now_ticks, input ready);
  modport sink   (input valid, input key_matrix, input now_ticks, output ready);
endinterface

interface kmdr_out_if;
  logic                              valid;
  logic                              ready;
  logic                              event_kind;
  logic [kmdr_pkg::KEY_ID_W-1:0]     key_id;
  logic                              last_of_run;

  modport source (output valid, output event_kind, output key_id, output last_of_run,
                  input ready);
  modport sink   (input valid, input event_kind, input key_id, input last_of_run,
                  output ready);
endinterface

[rtl/core/key_matrix_debounce_repeat_top.sv]
// Key matrix debouncer with typematic repeat, sequenced around one shared elapsed-time compare.
// Per snapshot beat: the debounce step, a scan of every key when the stable state changes,
//   the repeat step and a flush of the holding slot; scan and repeat hold while an event
//   waits for the holding slot because the output side stalls. No new snapshot is taken
//   until the flush is done: ready is high only while the sequencer is idle.
// Reset (rst_ni low, asynchronous): registers return to 20/500/100, debouncer waits for
//   all keys released, repeat is idle, no event is pending.
module key_matrix_debounce_repeat_top #(
  parameter int unsigned NUM_ROWS    = 8,
  parameter int unsigned NUM_COLUMNS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kmdr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [kmdr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  kmdr_in_if.sink                           in_i,
  kmdr_out_if.source                        out_o
);

  localparam int unsigned NUM_KEYS  = NUM_ROWS * NUM_COLUMNS;
  localparam int unsigned KEY_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [KEY_IDX_W-1:0] LAST_KEY = KEY_IDX_W'(NUM_KEYS - 1);

  // Configuration registers
  logic [kmdr_pkg::TICK_W-1:0] debounce_ticks_q, initial_ticks_q, repeat_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q <= kmdr_pkg::DEBOUNCE_TICKS_RST;
      initial_ticks_q  <= kmdr_pkg::INITIAL_REPEAT_TICKS_RST;
      repeat_ticks_q   <= kmdr_pkg::REPEAT_TICKS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kmdr_pkg::CFG_DEBOUNCE_TICKS:       debounce_ticks_q <= cfg_data_i;
        kmdr_pkg::CFG_INITIAL_REPEAT_TICKS: initial_ticks_q  <= cfg_data_i;
        kmdr_pkg::CFG_REPEAT_TICKS:         repeat_ticks_q   <= cfg_data_i;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // Sequencer and block state
  kmdr_pkg::seq_e       seq_q, seq_d;
  kmdr_pkg::deb_phase_e deb_phase_q;
  kmdr_pkg::rep_phase_e rep_phase_q;

  logic [NUM_KEYS-1:0]              snap_q;
  logic [kmdr_pkg::TICK_W-1:0]      now_q;
  logic [NUM_KEYS-1:0]              stable_q, cand_q;
  logic [kmdr_pkg::TICK_W-1:0]      deb_start_q, rep_start_q;
  logic [kmdr_pkg::KEY_ID_W-1:0]    repeat_key_q;
  logic                             repeat_key_valid_q;
  logic [KEY_IDX_W-1:0]             scan_idx_q;

  // Holding slot: the newest event waits here until we know whether another follows,
  // which settles its last_of_run flag.
  logic                             hold_valid_q;
  logic                             hold_kind_q;
  logic [kmdr_pkg::KEY_ID_W-1:0]    hold_code_q;

  logic                             out_valid_q;
  logic                             out_kind_q;
  logic [kmdr_pkg::KEY_ID_W-1:0]    out_code_q;
  logic                             out_last_q;

  // Shared elapsed-time unit: the debounce step and the repeat step take turns on it.
  logic [kmdr_pkg::TICK_W-1:0] elap_start, elap_delay, elap_diff;
  logic                        elapsed;

  always_comb begin
    if (seq_q == kmdr_pkg::SEQ_DEB) begin
      elap_start = deb_start_q;
      elap_delay = debounce_ticks_q;
    end else begin
      elap_start = rep_start_q;
      elap_delay = (rep_phase_q == kmdr_pkg::REP_INITIAL) ? initial_ticks_q : repeat_ticks_q;
    end
  end

  assign elap_diff = now_q - elap_start;   // wraps modulo the tick range
  assign elapsed   = (elap_diff >= elap_delay);

  // Step decodes
  logic                            stable_change;
  logic                            scan_release, scan_press;
  logic [kmdr_pkg::KEY_ID_W-1:0]   scan_code;
  logic                            rep_emit;
  logic                            out_free;
  logic                            push_req, push_ok, stall;
  logic                            push_kind;
  logic [kmdr_pkg::KEY_ID_W-1:0]   push_code;
  logic                            flush_go;
  logic                            out_load;

  assign stable_change = (deb_phase_q == kmdr_pkg::DEB_SETTLE) && (snap_q == cand_q) &&
                         elapsed && (snap_q != stable_q);

  assign scan_release = !snap_q[scan_idx_q] && stable_q[scan_idx_q];
  assign scan_press   = snap_q[scan_idx_q] && !stable_q[scan_idx_q];
  assign scan_code    = kmdr_pkg::KEY_ID_W'(scan_idx_q);

  always_comb begin
    case (rep_phase_q)
      kmdr_pkg::REP_MAKE:                           rep_emit = 1'b1;
      kmdr_pkg::REP_INITIAL, kmdr_pkg::REP_REPEAT:  rep_emit = elapsed;
      default:                                      rep_emit = 1'b0;
    endcase
  end

  assign out_free  = !out_valid_q || out_o.ready;
  assign push_req  = ((seq_q == kmdr_pkg::SEQ_SCAN) && scan_release) ||
                     ((seq_q == kmdr_pkg::SEQ_REP) && rep_emit);
  assign push_kind = (seq_q == kmdr_pkg::SEQ_SCAN) ? kmdr_pkg::EVENT_BREAK
                                                   : kmdr_pkg::EVENT_MAKE;
  assign push_code = (seq_q == kmdr_pkg::SEQ_SCAN) ? scan_code : repeat_key_q;
  // A new event can enter the slot if it is empty or the old one moves to the output.
  assign push_ok   = !hold_valid_q || out_free;
  assign stall     = push_req && !push_ok;
  assign flush_go  = (seq_q == kmdr_pkg::SEQ_FLUSH) && (!hold_valid_q || out_free);
  assign out_load  = hold_valid_q && ((push_req && push_ok) || flush_go);

  assign in_i.ready = (seq_q == kmdr_pkg::SEQ_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= kmdr_pkg::SEQ_IDLE;
    end else begin
      seq_q <= seq_d;
    end
  end

  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      kmdr_pkg::SEQ_IDLE:  if (in_i.valid) seq_d = kmdr_pkg::SEQ_DEB;
      kmdr_pkg::SEQ_DEB:   seq_d = stable_change ? kmdr_pkg::SEQ_SCAN : kmdr_pkg::SEQ_REP;
      kmdr_pkg::SEQ_SCAN:  if (!stall && scan_idx_q == LAST_KEY) seq_d = kmdr_pkg::SEQ_REP;
      kmdr_pkg::SEQ_REP:   if (!stall) seq_d = kmdr_pkg::SEQ_FLUSH;
      kmdr_pkg::SEQ_FLUSH: if (flush_go) seq_d = kmdr_pkg::SEQ_IDLE;
      default:             seq_d = kmdr_pkg::SEQ_IDLE;
    endcase
  end

  // Snapshot capture
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      snap_q <= in_i.key_matrix[NUM_KEYS-1:0];  // keys outside the matrix are ignored
      now_q  <= in_i.now_ticks;
    end
  end

  // Debounce, scan and repeat state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_phase_q        <= kmdr_pkg::DEB_WAIT;
      stable_q           <= '0;
      cand_q             <= '0;
      deb_start_q        <= '0;
      rep_phase_q        <= kmdr_pkg::REP_IDLE;
      repeat_key_q       <= '0;
      repeat_key_valid_q <= 1'b0;
      rep_start_q        <= '0;
      scan_idx_q         <= '0;
    end else begin
      case (seq_q)
        kmdr_pkg::SEQ_DEB: begin
          scan_idx_q <= '0;
          case (deb_phase_q)
            kmdr_pkg::DEB_IDLE: begin
              if (snap_q != stable_q) begin
                deb_phase_q <= kmdr_pkg::DEB_SETTLE;
                cand_q      <= snap_q;
                deb_start_q <= now_q;
              end
            end
            kmdr_pkg::DEB_SETTLE: begin
              if (snap_q != cand_q) begin
                cand_q      <= snap_q;
                deb_start_q <= now_q;
              end else if (elapsed) begin
                deb_phase_q <= kmdr_pkg::DEB_IDLE;
              end
            end
            default: begin
              // wait until a snapshot shows every key released
              stable_q    <= '0;
              deb_phase_q <= (snap_q == '0) ? kmdr_pkg::DEB_IDLE : kmdr_pkg::DEB_WAIT;
            end
          endcase
        end
        kmdr_pkg::SEQ_SCAN: begin
          if (!stall) begin
            if (scan_release) begin
              if (repeat_key_valid_q && repeat_key_q == scan_code) begin
                repeat_key_valid_q <= 1'b0;
                rep_phase_q        <= kmdr_pkg::REP_IDLE;
              end
            end else if (scan_press) begin
              // newest press wins the repeat
              repeat_key_q       <= scan_code;
              repeat_key_valid_q <= 1'b1;
              rep_phase_q        <= kmdr_pkg::REP_MAKE;
            end
            if (scan_idx_q == LAST_KEY) begin
              stable_q <= snap_q;
            end else begin
              scan_idx_q <= scan_idx_q + 1'b1;
            end
          end
        end
        kmdr_pkg::SEQ_REP: begin
          if (!stall) begin
            case (rep_phase_q)
              kmdr_pkg::REP_MAKE: begin
                if (initial_ticks_q != '0) begin
                  rep_start_q <= now_q;
                  rep_phase_q <= kmdr_pkg::REP_INITIAL;
                end else begin
                  rep_phase_q <= kmdr_pkg::REP_IDLE;
                end
              end
              kmdr_pkg::REP_INITIAL: begin
                if (elapsed) begin
                  if (repeat_ticks_q != '0) begin
                    rep_start_q <= now_q;
                    rep_phase_q <= kmdr_pkg::REP_REPEAT;
                  end else begin
                    rep_phase_q <= kmdr_pkg::REP_IDLE;
                  end
                end
              end
              kmdr_pkg::REP_REPEAT: begin
                if (elapsed) rep_start_q <= now_q;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Holding slot and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (push_req && push_ok) begin
        hold_valid_q <= 1'b1;
      end else if (flush_go) begin
        hold_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_req && push_ok) begin
      hold_kind_q <= push_kind;
      hold_code_q <= push_code;
    end
    if (out_load) begin
      out_kind_q <= hold_kind_q;
      out_code_q <= hold_code_q;
      out_last_q <= (seq_q == kmdr_pkg::SEQ_FLUSH);  // only the flushed beat ends the run
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.event_kind  = out_kind_q;
  assign out_o.key_id      = out_code_q;
  assign out_o.last_of_run = out_last_q;

  // Assertions
  a_idle_slot_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == kmdr_pkg::SEQ_IDLE) |-> !hold_valid_q)
    else $error("holding slot not empty while accepting snapshots");

  a_wait_stable_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (deb_phase_q == kmdr_pkg::DEB_WAIT) |-> (stable_q == '0))
    else $error("stable state nonzero while waiting for release");

  a_repeat_needs_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !repeat_key_valid_q |-> (rep_phase_q == kmdr_pkg::REP_IDLE))
    else $error("repeat active without a repeat key");

  a_stall_holds_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == kmdr_pkg::SEQ_SCAN && stall) |=> (scan_idx_q == $past(scan_idx_q)))
    else $error("scan advanced while its event was stalled");

endmodule
